FILE: rtl/p2s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2s_pkg
// Shared types, constants and elaboration-time lookup tables for the
// pixel to sRGB8 converter.
// ----------------------------------------------------------------------------
package p2s_pkg;

  // Source pixel formats held in the configuration register.
  typedef enum logic [1:0] {
    FMT_F32    = 2'd0,
    FMT_UNORM8 = 2'd1,
    FMT_UF11   = 2'd2,
    FMT_COPY   = 2'd3
  } fmt_e;

  localparam int unsigned LinW       = 25;
  localparam int unsigned QueueDepth = 4;
  localparam logic [LinW-1:0] OneQ24 = 25'h100_0000;
  // Largest Q0.24 value that still uses the linear segment.
  localparam longint unsigned LinMaxL = (64'd31308 * 64'd16777216) / 64'd10000000;
  localparam logic [LinW-1:0] LinMax = LinW'(LinMaxL);

  typedef logic [LinW-1:0] thr_tab_t [256];

  // Classified pixel as it waits in the queue.
  typedef struct packed {
    logic [2:0][LinW-1:0] lin;
    logic [2:0][7:0]      direct;
    logic [7:0]           alpha;
    logic                 copy;
  } item_t;

  // Smallest L whose power-segment code reaches k:
  // L^5 * 53805^12 >= (200k + 2705)^12 * 2^120.
  function automatic thr_tab_t pow_thr_f();
    thr_tab_t     t;
    logic [383:0] c;
    logic [383:0] r;
    logic [383:0] p;
    logic [25:0]  lo;
    logic [25:0]  hi;
    logic [25:0]  mid;
    c = 384'd1;
    for (int i = 0; i < 12; i++) c = c * 384'd53805;
    for (int k = 0; k < 256; k++) begin
      r = 384'd1;
      for (int i = 0; i < 12; i++) r = r * (384'd200 * 384'(k) + 384'd2705);
      r = r << 120;
      lo = 26'd0;
      hi = 26'h100_0001;
      for (int it = 0; it < 26; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          p = 384'(mid);
          for (int i = 0; i < 4; i++) p = p * 384'(mid);
          p = p * c;
          if (p >= r) hi = mid;
          else lo = mid + 26'd1;
        end
      end
      t[k] = lo[LinW-1:0];
    end
    return t;
  endfunction

  // Smallest L whose linear-segment code reaches k.
  function automatic thr_tab_t lin_thr_f();
    thr_tab_t         t;
    longint unsigned  num;
    longint unsigned  q;
    t[0] = '0;
    for (int k = 1; k < 256; k++) begin
      num = (64'd200 * 64'(k) - 64'd100) << 24;
      q = (num + 64'd658919) / 64'd658920;
      t[k] = (q > 64'h1FF_FFFF) ? 25'h1FF_FFFF : LinW'(q);
    end
    return t;
  endfunction

  // Unorm byte to Q0.24, rounded.
  function automatic thr_tab_t byte_tab_f();
    thr_tab_t t;
    for (int b = 0; b < 256; b++) begin
      t[b] = LinW'(((64'(b) << 24) + 64'd127) / 64'd255);
    end
    return t;
  endfunction

  localparam thr_tab_t PowThr  = pow_thr_f();
  localparam thr_tab_t LinThr  = lin_thr_f();
  localparam thr_tab_t ByteTab = byte_tab_f();

endpackage

FILE: rtl/pixel_to_srgb8_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_srgb8_converter_top
// An input pixel passes the queue, eight search stages and the output register.
// Throughput: one pixel per cycle while not stalled; the search is pipelined.
// A four-entry queue lets the input side run while the output is stalled.
// Reset is asynchronous and active low; it empties the queue and pipeline
// and sets the source format to float32. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pixel_to_srgb8_converter_top #(
  parameter int unsigned QueueDepth = p2s_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_data_i,      // source_format
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,    // word0, word1, word2, word3
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata     // red_out, green_out, blue_out, alpha_out
);
  import p2s_pkg::*;

  fmt_e  fmt_q;
  item_t fr_item, q_item;
  logic  full, empty, pop, push;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fmt_q <= FMT_F32;
    else if (cfg_we_i) fmt_q <= fmt_e'(cfg_data_i);
  end

  assign s_axis_tready = !full;
  assign push = s_axis_tvalid && !full;

  p2s_front u_front (
    .pix_i  (s_axis_tdata),
    .fmt_i  (fmt_q),
    .item_o (fr_item)
  );

  p2s_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (fr_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_item)
  );

  p2s_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .item_i     (q_item),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

FILE: rtl/p2s_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2s_front
// Decodes one input pixel into linear Q0.24 channels and an alpha byte.
// ----------------------------------------------------------------------------
module p2s_front (
  input  logic [127:0]          pix_i,
  input  p2s_pkg::fmt_e         fmt_i,
  output p2s_pkg::item_t        item_o
);
  import p2s_pkg::*;

  // Float32 to Q0.24 with round half up.
  function automatic logic [LinW-1:0] f32_q24(input logic [31:0] w);
    logic [7:0]  e;
    logic [7:0]  sh;
    logic [24:0] ext;
    logic [24:0] t;
    logic [LinW-1:0] res;
    e = w[30:23];
    sh = 8'd126 - e;
    ext = {1'b1, w[22:0], 1'b0};
    t = (ext >> sh[4:0]) + 25'd1;
    if (e == 8'hFF) res = (w[22:0] != '0 || w[31]) ? '0 : OneQ24;
    else if (w[31] || e == 8'd0) res = '0;
    else if (e >= 8'd127) res = OneQ24;
    else if (sh >= 8'd25) res = '0;
    else res = {1'b0, t[24:1]};
    return res;
  endfunction

  // Unsigned 11-bit float (6-bit mantissa) to Q0.24.
  function automatic logic [LinW-1:0] uf_q24(input logic [10:0] v);
    logic [4:0] e;
    logic [5:0] m;
    logic [LinW-1:0] res;
    e = v[10:6];
    m = v[5:0];
    if (e == 5'd0) res = LinW'(m) << 4;
    else if (e == 5'd31) res = (m != '0) ? '0 : OneQ24;
    else if (e >= 5'd15) res = OneQ24;
    else res = LinW'({1'b1, m}) << (e + 5'd3);
    return res;
  endfunction

  logic [3:0][31:0] w;
  logic [LinW-1:0]  a_lin;
  logic [32:0]      a_sum;

  assign w = pix_i;
  assign a_lin = f32_q24(w[3]);
  assign a_sum = ({a_lin, 8'd0} - {8'd0, a_lin}) + 33'h080_0000;

  // Classify the pixel by source format.
  always_comb begin
    item_o.direct = {w[2][7:0], w[1][7:0], w[0][7:0]};
    item_o.copy = 1'b0;
    item_o.alpha = w[3][7:0];
    item_o.lin = '0;
    unique case (fmt_i)
      FMT_F32: begin
        for (int c = 0; c < 3; c++) item_o.lin[c] = f32_q24(w[c]);
        item_o.alpha = a_sum[31:24];
      end
      FMT_UNORM8: begin
        for (int c = 0; c < 3; c++) item_o.lin[c] = ByteTab[w[c][7:0]];
      end
      FMT_UF11: begin
        item_o.lin[0] = uf_q24(w[0][10:0]);
        item_o.lin[1] = uf_q24(w[0][21:11]);
        item_o.lin[2] = uf_q24({w[0][31:22], 1'b0});
        item_o.alpha = 8'hFF;
      end
      FMT_COPY: begin
        item_o.copy = 1'b1;
      end
      default: item_o.copy = 1'b0;
    endcase
  end

endmodule

FILE: rtl/p2s_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2s_fifo
// Short queue of classified pixels between the front and back parts.
// ----------------------------------------------------------------------------
module p2s_fifo #(
  parameter int unsigned Depth = p2s_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  p2s_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output p2s_pkg::item_t data_o
);
  import p2s_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

FILE: rtl/p2s_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2s_back
// Eight-stage binary search of the sRGB threshold tables, then output register.
// ----------------------------------------------------------------------------
module p2s_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  p2s_pkg::item_t item_i,
  output logic           pop_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic [31:0]    m_tdata_o
);
  import p2s_pkg::*;

  localparam int unsigned Stages = 8;

  typedef struct packed {
    item_t           it;
    logic [2:0][7:0] klin;
    logic [2:0][7:0] kpow;
  } stg_t;

  // One search step: try setting bit b of each code.
  function automatic stg_t step(input stg_t s, input int b);
    stg_t r;
    logic [7:0] cl;
    logic [7:0] cp;
    r = s;
    for (int c = 0; c < 3; c++) begin
      cl = s.klin[c] | (8'd1 << b);
      cp = s.kpow[c] | (8'd1 << b);
      if (s.it.lin[c] >= LinThr[cl]) r.klin[c] = cl;
      if (s.it.lin[c] >= PowThr[cp]) r.kpow[c] = cp;
    end
    return r;
  endfunction

  logic              en;
  logic [Stages-1:0] v_q;
  stg_t              st_q [Stages];
  stg_t              st_in [Stages];
  logic              out_v_q;
  logic [31:0]       out_d_q;
  logic [31:0]       res_d;

  // The whole pipeline moves unless the output is held.
  assign en = !(out_v_q && !m_tready_i);
  assign pop_o = en && !empty_i;

  assign st_in[0] = '{it: item_i, klin: '0, kpow: '0};
  for (genvar g = 1; g < Stages; g++) begin : g_link
    assign st_in[g] = st_q[g-1];
  end

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en) begin
        v_q[g] <= (g == 0) ? !empty_i : v_q[(g == 0) ? 0 : g-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) st_q[g] <= step(st_in[g], Stages - 1 - g);
    end
  end

  // Pick the segment code per channel and pack the pixel.
  always_comb begin
    res_d = {st_q[Stages-1].it.alpha, 24'd0};
    for (int c = 0; c < 3; c++) begin
      if (st_q[Stages-1].it.copy) res_d[c*8 +: 8] = st_q[Stages-1].it.direct[c];
      else if (st_q[Stages-1].it.lin[c] <= LinMax) res_d[c*8 +: 8] = st_q[Stages-1].klin[c];
      else res_d[c*8 +: 8] = st_q[Stages-1].kpow[c];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v_q[Stages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_d_q <= res_d;
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_d_q;

endmodule

FILE: rtl/p2s_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2s_checker
// Port-level checks for the pixel to sRGB8 converter.
// ----------------------------------------------------------------------------
module p2s_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata
);

  // A stalled output transaction keeps its valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // A stalled output transaction keeps its data.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  // The queue only fills up behind a stalled output.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // No result appears right after reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

endmodule

bind pixel_to_srgb8_converter_top p2s_checker u_p2s_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/srgb8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb8_checker
// Watches both stream channels and the format register of the pixel to
// sRGB8 converter. It predicts the RGBA8 result of each accepted pixel and
// compares each output transaction, channel by channel, with the oldest one.
// ----------------------------------------------------------------------------
module srgb8_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [31:0]  m_axis_tdata,
  output int           mismatch_count_o,
  output int           pending_count_o
);
  import p2s_pkg::*;

  localparam logic [24:0] Q24One = 25'h100_0000;

  fmt_e        cur_fmt;
  logic [31:0] expected_pixels [$];

  // Exact sRGB curve on a Q0.24 linear value.
  function automatic logic [7:0] srgb_encode(input logic [24:0] lin);
    logic [383:0] lhs;
    logic [383:0] rhs;
    longint unsigned num;
    int lo;
    int hi;
    int mid;
    if (lin > Q24One) lin = Q24One;
    if (64'(lin) * 64'd10000000 <= 64'd31308 * 64'd16777216) begin
      num = (64'd2 * 64'd1292 * 64'd255 * 64'(lin) + 64'd100 * 64'd16777216)
            / (64'd200 * 64'd16777216);
      return (num > 255) ? 8'hff : 8'(num);
    end
    lhs = 384'd1;
    for (int i = 0; i < 5; i++) lhs = lhs * 384'(lin);
    for (int i = 0; i < 12; i++) lhs = lhs * 384'd53805;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      rhs = 384'd1;
      for (int i = 0; i < 12; i++) rhs = rhs * (384'd200 * 384'(mid) + 384'd2705);
      rhs = rhs << 120;
      if (lhs >= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 8'(lo);
  endfunction

  // Single float bits to Q0.24, clamped, rounded half up.
  function automatic logic [24:0] f32_lin(input logic [31:0] w);
    logic [7:0]  ex;
    logic [23:0] mant;
    int          sh;
    ex = w[30:23];
    if (ex == 8'hff) return (w[22:0] != 0 || w[31]) ? 25'd0 : Q24One;
    if (w[31] || ex == 0) return 25'd0;
    if (ex >= 8'd127) return Q24One;
    sh = 126 - int'(ex);
    mant = {1'b1, w[22:0]};
    if (sh == 0) return 25'(mant);
    if (sh >= 25) return 25'd0;
    return 25'((32'(mant) + (32'd1 << (sh - 1))) >> sh);
  endfunction

  // Unsigned small float to Q0.24; mb is the mantissa width.
  function automatic logic [24:0] uf_lin(input logic [10:0] bits, input int mb);
    logic [5:0]  m;
    logic [4:0]  ex;
    m = 6'(bits & ((11'd1 << mb) - 11'd1));
    ex = 5'(bits >> mb);
    if (ex == 0) return 25'(32'(m) << (10 - mb));
    if (ex == 5'd31) return (m != 0) ? 25'd0 : Q24One;
    if (ex >= 5'd15) return Q24One;
    return 25'(((32'd1 << mb) | 32'(m)) << (int'(ex) + 9 - mb));
  endfunction

  function automatic logic [24:0] unorm_lin(input logic [7:0] b);
    return 25'(((64'(b) << 24) + 64'd127) / 64'd255);
  endfunction

  function automatic logic [31:0] predict_pixel(input fmt_e f, input logic [127:0] d);
    logic [31:0] w0, w1, w2, w3;
    logic [7:0]  r, g, b, a;
    w0 = d[31:0];
    w1 = d[63:32];
    w2 = d[95:64];
    w3 = d[127:96];
    case (f)
      FMT_F32: begin
        r = srgb_encode(f32_lin(w0));
        g = srgb_encode(f32_lin(w1));
        b = srgb_encode(f32_lin(w2));
        a = 8'((64'(f32_lin(w3)) * 64'd255 + (64'd1 << 23)) >> 24);
      end
      FMT_UNORM8: begin
        r = srgb_encode(unorm_lin(w0[7:0]));
        g = srgb_encode(unorm_lin(w1[7:0]));
        b = srgb_encode(unorm_lin(w2[7:0]));
        a = w3[7:0];
      end
      FMT_UF11: begin
        r = srgb_encode(uf_lin(w0[10:0], 6));
        g = srgb_encode(uf_lin(w0[21:11], 6));
        b = srgb_encode(uf_lin({1'b0, w0[31:22]}, 5));
        a = 8'hff;
      end
      default: begin
        r = w0[7:0];
        g = w1[7:0];
        b = w2[7:0];
        a = w3[7:0];
      end
    endcase
    return {a, b, g, r};
  endfunction

  assign pending_count_o = expected_pixels.size();

  // Track the register, queue predictions and compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] exp_px;
    if (!rst_ni) begin
      cur_fmt <= FMT_F32;
      expected_pixels.delete();
      mismatch_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_pixels = {expected_pixels, predict_pixel(cur_fmt, s_axis_tdata)};
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("unexpected output transaction %h", m_axis_tdata);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (exp_px !== m_axis_tdata) begin
            if (mismatch_count_o < 10)
              $display("mismatch: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                       exp_px[7:0], exp_px[15:8], exp_px[23:16], exp_px[31:24],
                       m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                       m_axis_tdata[31:24]);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (cfg_we_i) cur_fmt <= fmt_e'(cfg_data_i);
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixels of every source format through the converter under several
// idle and stall patterns; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module testbench;
  import p2s_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  int           mismatch_count;
  int           pending_count;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pixel_to_srgb8_converter_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  srgb8_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .mismatch_count_o(mismatch_count), .pending_count_o(pending_count)
  );

  // Receiver back-pressure.
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 300000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one pixel and hold it until the transaction completes.
  task automatic send_pixel(input logic [127:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Let the block drain fully, then write the format register.
  task automatic set_format(input fmt_e f);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (14) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= f;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [31:0] rand_f32();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return $urandom();
      1: return {1'b0, 8'hff, 23'($urandom_range(1, 8388607))};
      2: return {1'b0, 8'($urandom_range(0, 2)), 23'($urandom())};
      3: return {1'b0, 8'($urandom_range(127, 254)), 23'($urandom())};
      4: return {1'b1, 8'($urandom_range(100, 126)), 23'($urandom())};
      default: return {1'b0, 8'($urandom_range(95, 126)), 23'($urandom())};
    endcase
  endfunction

  function automatic logic [10:0] rand_uf(input int mb);
    logic [10:0] v;
    v = 11'($urandom());
    if ($urandom_range(3) != 0) v[mb +: 5] = 5'($urandom_range(0, 15));
    return v;
  endfunction

  function automatic logic [127:0] rand_pixel(input fmt_e f);
    logic [127:0] d;
    logic [10:0]  blue_uf;
    d = {$urandom(), $urandom(), $urandom(), $urandom()};
    if (f == FMT_F32) d = {rand_f32(), rand_f32(), rand_f32(), rand_f32()};
    if (f == FMT_UF11 && $urandom_range(3) != 0) begin
      blue_uf = rand_uf(5);
      d[31:0] = {blue_uf[9:0], rand_uf(6), rand_uf(6)};
    end
    return d;
  endfunction

  fmt_e fmt_list [4] = '{FMT_F32, FMT_UNORM8, FMT_UF11, FMT_COPY};
  int   stall_pct_list [4] = '{0, 0, 47, 38};
  int   idle_pct_list [4] = '{0, 47, 0, 38};

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Float extremes and special values at the reset format.
    send_pixel({32'h3f80_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fc0_0000});
    send_pixel({32'h7f80_0000, 32'hff80_0000, 32'h0000_0001, 32'h3b4d_2e1c});
    send_pixel({32'h3f7f_ffff, 32'h3b4d_2e1c, 32'h3b4d_2e1d, 32'h3400_0000});
    send_pixel({32'hbf80_0000, 32'h4000_0000, 32'h3300_0000, 32'hffff_ffff});
    send_pixel({32'h3e80_0000, 32'h7f7f_ffff, 32'h3f00_0000, 32'h3c00_0000});
    set_format(FMT_UNORM8);
    send_pixel({32'hffff_ff00, 32'h0000_00ff, 32'h0000_0000, 32'h1234_5601});
    send_pixel({32'h0000_00aa, 32'hffff_ff01, 32'h0000_0080, 32'h0000_00ff});
    set_format(FMT_UF11);
    send_pixel({4{32'h0000_0000}});
    send_pixel({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_pixel({96'h0, 10'h3e0, 11'h7c0, 11'h7c0});
    send_pixel({96'h0, 10'h01f, 11'h03f, 11'h001});
    send_pixel({96'h0, 10'h1e0, 11'h3c0, 11'h3bf});
    send_pixel({96'h0, 10'h3c0, 11'h780, 11'h1ff});
    set_format(FMT_COPY);
    send_pixel({32'hdead_beef, 32'h0000_0000, 32'hffff_ffff, 32'h1234_5678});
    send_pixel({4{32'hffff_ffff}});

    // Random pixels over every format and pressure pattern.
    for (int ph = 0; ph < 16; ph++) begin
      set_format(fmt_list[ph % 4]);
      send_idle_pct  = idle_pct_list[ph / 4];
      recv_stall_pct = stall_pct_list[ph / 4];
      for (int n = 0; n < 40; n++) send_pixel(rand_pixel(fmt_list[ph % 4]));
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
